@@ rtl/longest_increasing_subsequence_engine_assert.svh @@
// Assertion macros for the longest increasing subsequence engine.
// Used by the top level only; no other dependencies.
`ifndef LONGEST_INCREASING_SUBSEQUENCE_ENGINE_ASSERT_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_ENGINE_ASSERT_SVH

// Check a condition at every clock edge out of reset.
`define LISE_ASSERT_ALWAYS(label, ck, rn, cond) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond)) \
        else $error("lise: invariant violated");

// Check a consequent in the same cycle as its antecedent.
`define LISE_ASSERT_SAME(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("lise: same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define LISE_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("lise: next-cycle check failed");

`endif

@@ rtl/lise_pkg.sv @@
// Shared types and constants of the longest increasing subsequence engine.
// No dependencies; used by lise_cmp, lise_ctrl and the top level.
`default_nettype none

package lise_pkg;

    localparam int MaxItems  = 1024;
    localparam int ValueBits = 32;
    localparam int IdxBits   = 10;
    localparam int LenBits   = 11;

    localparam logic [1:0] FuncLoad  = 2'd0;
    localparam logic [1:0] FuncRead  = 2'd1;
    localparam logic [1:0] FuncClear = 2'd2;

    localparam logic [LenBits-1:0] NoPred = LenBits'(MaxItems);

    typedef struct packed {
        logic [1:0]                  func;
        logic signed [ValueBits-1:0] value;
    } req_t;

    typedef struct packed {
        logic [LenBits-1:0]          lis_length;
        logic signed [ValueBits-1:0] elem_value;
        logic [IdxBits-1:0]          elem_index;
        logic                        elem_valid;
        logic                        elem_last;
        logic                        overflow;
    } rsp_t;

    typedef struct packed {
        logic [ValueBits-1:0] value;
        logic [IdxBits-1:0]   pos;
    } tail_entry_t;

    typedef struct packed {
        logic [ValueBits-1:0] value;
        logic [LenBits-1:0]   pred;
    } item_entry_t;

    typedef struct packed {
        logic               we;
        logic [IdxBits-1:0] waddr;
        tail_entry_t        wdata;
        logic [IdxBits-1:0] raddr;
    } tail_port_t;

    typedef struct packed {
        logic               we;
        logic [IdxBits-1:0] waddr;
        item_entry_t        wdata;
        logic [IdxBits-1:0] raddr;
    } item_port_t;

    typedef struct packed {
        logic               we;
        logic [IdxBits-1:0] waddr;
        logic [IdxBits-1:0] wdata;
        logic [IdxBits-1:0] raddr;
    } order_port_t;

    typedef struct packed {
        logic [LenBits-1:0] item_count;
        logic [LenBits-1:0] run_length;
    } stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LAST,
        ST_SEARCH,
        ST_PRED,
        ST_WRITE,
        ST_B_HEAD,
        ST_B_WALK,
        ST_B_NEXT,
        ST_R_ORD,
        ST_R_ITEM,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

@@ rtl/lise_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lise_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/lise_cmp.sv @@
// Shared signed less-than unit used by every tail probe.
// Depends on lise_pkg.
`default_nettype none

module lise_cmp (
    input  wire logic [lise_pkg::ValueBits-1:0] a,
    input  wire logic [lise_pkg::ValueBits-1:0] b,
    output logic                                lt
);

    localparam int Msb = lise_pkg::ValueBits - 1;

    logic [lise_pkg::ValueBits-1:0] key_a;
    logic [lise_pkg::ValueBits-1:0] key_b;

    // flip the sign bit for an order-preserving unsigned key
    assign key_a = {~a[Msb], a[Msb-1:0]};
    assign key_b = {~b[Msb], b[Msb-1:0]};
    assign lt    = key_a < key_b;

endmodule

`default_nettype wire

@@ rtl/lise_ctrl.sv @@
// Sequencer of the engine: load with binary search, clear, chain walk, readout, response register.
// Depends on lise_pkg and lise_cmp.
`default_nettype none

module lise_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire lise_pkg::req_t        req_data,
    output logic                       rsp_valid,
    input  wire logic                  rsp_ready,
    output lise_pkg::rsp_t             rsp_data,
    output lise_pkg::tail_port_t       tail_port,
    input  wire lise_pkg::tail_entry_t tail_rdata,
    output lise_pkg::item_port_t       item_port,
    input  wire lise_pkg::item_entry_t item_rdata,
    output lise_pkg::order_port_t      order_port,
    input  wire logic [lise_pkg::IdxBits-1:0] order_rdata,
    output lise_pkg::stat_t            stat
);

    localparam int IB = lise_pkg::IdxBits;
    localparam int LB = lise_pkg::LenBits;

    lise_pkg::state_t state_reg, state_next;

    logic [LB-1:0] count_reg, count_next;
    logic [LB-1:0] run_reg, run_next;
    logic [LB-1:0] ptr_reg, ptr_next;
    logic          rdy_reg, rdy_next;
    logic          rsp_valid_reg, rsp_valid_next;

    logic [lise_pkg::ValueBits-1:0] value_reg, value_next;
    logic [IB-1:0] lo_reg, lo_next;
    logic [IB-1:0] hi_reg, hi_next;
    logic [IB-1:0] mid_reg, mid_next;
    logic [IB-1:0] slot_reg, slot_next;
    logic [LB-1:0] pred_reg, pred_next;
    logic [LB-1:0] k_reg, k_next;
    logic [LB-1:0] cur_reg, cur_next;
    lise_pkg::rsp_t res_reg, res_next;
    lise_pkg::rsp_t rsp_reg, rsp_next;

    logic          tail_lt;
    logic [LB-1:0] last_idx;
    logic [IB-1:0] first_mid;
    logic [IB-1:0] lo_n;
    logic [IB-1:0] hi_n;
    logic [IB-1:0] mid_n;
    logic          search_more;
    logic [LB-1:0] k_dec;
    logic          rsp_free;

    lise_cmp u_cmp (
        .a  (tail_rdata.value),
        .b  (value_reg),
        .lt (tail_lt)
    );

    assign last_idx    = run_reg - LB'(1);
    assign first_mid   = last_idx[IB-1:0] >> 1;
    assign lo_n        = tail_lt ? (mid_reg + IB'(1)) : lo_reg;
    assign hi_n        = tail_lt ? hi_reg : mid_reg;
    assign search_more = lo_n < hi_n;
    assign mid_n       = lo_n + ((hi_n - lo_n) >> 1);
    assign k_dec       = k_reg - LB'(1);
    assign rsp_free    = !rsp_valid_reg || rsp_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lise_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req_data.func)
                        lise_pkg::FuncLoad:
                        begin
                            if (count_reg == lise_pkg::NoPred)
                                state_next = lise_pkg::ST_RESP;
                            else if (run_reg == '0)
                                state_next = lise_pkg::ST_WRITE;
                            else
                                state_next = lise_pkg::ST_LAST;
                        end
                        lise_pkg::FuncRead:
                        begin
                            if (rdy_reg)
                                state_next = (ptr_reg < run_reg) ? lise_pkg::ST_R_ORD
                                                                 : lise_pkg::ST_RESP;
                            else
                                state_next = (run_reg == '0) ? lise_pkg::ST_RESP
                                                             : lise_pkg::ST_B_HEAD;
                        end
                        default:
                        begin
                            state_next = lise_pkg::ST_RESP;
                        end
                    endcase
                end
            end
            lise_pkg::ST_LAST:
            begin
                if (tail_lt || last_idx == '0)
                    state_next = lise_pkg::ST_WRITE;
                else
                    state_next = lise_pkg::ST_SEARCH;
            end
            lise_pkg::ST_SEARCH:
            begin
                if (search_more)
                    state_next = lise_pkg::ST_SEARCH;
                else if (lo_n == '0)
                    state_next = lise_pkg::ST_WRITE;
                else
                    state_next = lise_pkg::ST_PRED;
            end
            lise_pkg::ST_PRED:   state_next = lise_pkg::ST_WRITE;
            lise_pkg::ST_WRITE:  state_next = lise_pkg::ST_RESP;
            lise_pkg::ST_B_HEAD: state_next = lise_pkg::ST_B_WALK;
            lise_pkg::ST_B_WALK: state_next = lise_pkg::ST_B_NEXT;
            lise_pkg::ST_B_NEXT:
            begin
                state_next = (k_reg == '0) ? lise_pkg::ST_R_ORD : lise_pkg::ST_B_WALK;
            end
            lise_pkg::ST_R_ORD:  state_next = lise_pkg::ST_R_ITEM;
            lise_pkg::ST_R_ITEM: state_next = lise_pkg::ST_RESP;
            lise_pkg::ST_RESP:
            begin
                if (rsp_free)
                    state_next = lise_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lise_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath updates
    always_comb
    begin
        count_next     = count_reg;
        run_next       = run_reg;
        ptr_next       = ptr_reg;
        rdy_next       = rdy_reg;
        value_next     = value_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        slot_next      = slot_reg;
        pred_next      = pred_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            lise_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    value_next = req_data.value;
                    res_next   = '0;
                    slot_next  = '0;
                    pred_next  = lise_pkg::NoPred;
                    k_next     = run_reg;
                    case (req_data.func)
                        lise_pkg::FuncLoad:
                        begin
                            if (count_reg == lise_pkg::NoPred)
                                res_next.overflow = 1'b1;
                        end
                        lise_pkg::FuncRead:
                        begin
                            if (!rdy_reg && run_reg == '0)
                            begin
                                rdy_next = 1'b1;
                                ptr_next = '0;
                            end
                        end
                        lise_pkg::FuncClear:
                        begin
                            count_next = '0;
                            run_next   = '0;
                            ptr_next   = '0;
                            rdy_next   = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            lise_pkg::ST_LAST:
            begin
                if (tail_lt)
                begin
                    slot_next = run_reg[IB-1:0];
                    pred_next = {1'b0, tail_rdata.pos};
                end
                else
                begin
                    lo_next  = '0;
                    hi_next  = last_idx[IB-1:0];
                    mid_next = first_mid;
                end
            end
            lise_pkg::ST_SEARCH:
            begin
                lo_next   = lo_n;
                hi_next   = hi_n;
                mid_next  = mid_n;
                slot_next = lo_n;
            end
            lise_pkg::ST_PRED:
            begin
                pred_next = {1'b0, tail_rdata.pos};
            end
            lise_pkg::ST_WRITE:
            begin
                if ({1'b0, slot_reg} == run_reg)
                    run_next = run_reg + LB'(1);
                count_next = count_reg + LB'(1);
                rdy_next   = 1'b0;
                ptr_next   = '0;
            end
            lise_pkg::ST_B_HEAD:
            begin
                cur_next = {1'b0, tail_rdata.pos};
            end
            lise_pkg::ST_B_WALK:
            begin
                k_next = k_dec;
            end
            lise_pkg::ST_B_NEXT:
            begin
                // hold the end-of-chain mark once reached
                if (!cur_reg[IB])
                    cur_next = item_rdata.pred;
                if (k_reg == '0)
                begin
                    rdy_next = 1'b1;
                    ptr_next = '0;
                end
            end
            lise_pkg::ST_R_ORD:
            begin
                res_next.elem_index = order_rdata;
            end
            lise_pkg::ST_R_ITEM:
            begin
                res_next.elem_value = item_rdata.value;
                res_next.elem_valid = 1'b1;
                res_next.elem_last  = (ptr_reg + LB'(1)) == run_reg;
                ptr_next            = ptr_reg + LB'(1);
            end
            lise_pkg::ST_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_next            = res_reg;
                    rsp_next.lis_length = run_reg;
                    rsp_valid_next      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // memory requests and handshake outputs
    always_comb
    begin
        req_ready = (state_reg == lise_pkg::ST_IDLE);

        tail_port.we    = (state_reg == lise_pkg::ST_WRITE);
        tail_port.waddr = slot_reg;
        tail_port.wdata = {value_reg, count_reg[IB-1:0]};

        item_port.we    = (state_reg == lise_pkg::ST_WRITE);
        item_port.waddr = count_reg[IB-1:0];
        item_port.wdata = {value_reg, pred_reg};

        order_port.we    = (state_reg == lise_pkg::ST_B_WALK);
        order_port.waddr = k_dec[IB-1:0];
        order_port.wdata = cur_reg[IB] ? '0 : cur_reg[IB-1:0];

        case (state_reg)
            lise_pkg::ST_LAST:   tail_port.raddr = first_mid;
            lise_pkg::ST_SEARCH: tail_port.raddr = search_more ? mid_n : (lo_n - IB'(1));
            default:             tail_port.raddr = last_idx[IB-1:0];
        endcase

        case (state_reg)
            lise_pkg::ST_B_WALK: item_port.raddr = cur_reg[IB-1:0];
            lise_pkg::ST_R_ORD:  item_port.raddr = order_rdata;
            default:             item_port.raddr = '0;
        endcase

        case (state_reg)
            lise_pkg::ST_B_NEXT: order_port.raddr = '0;
            default:             order_port.raddr = ptr_reg[IB-1:0];
        endcase
    end

    assign rsp_valid       = rsp_valid_reg;
    assign rsp_data        = rsp_reg;
    assign stat.item_count = count_reg;
    assign stat.run_length = run_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lise_pkg::ST_IDLE;
            count_reg     <= '0;
            run_reg       <= '0;
            ptr_reg       <= '0;
            rdy_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            run_reg       <= run_next;
            ptr_reg       <= ptr_next;
            rdy_reg       <= rdy_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        slot_reg  <= slot_next;
        pred_reg  <= pred_next;
        k_reg     <= k_next;
        cur_reg   <= cur_next;
        res_reg   <= res_next;
        rsp_reg   <= rsp_next;
    end

endmodule

`default_nettype wire

@@ rtl/longest_increasing_subsequence_engine.sv @@
// Top level of the longest increasing subsequence engine: sequencer and three RAMs.
// Depends on lise_pkg, lise_ram, lise_ctrl and the assertion macro header.
`default_nettype none

// The engine takes one request at a time and answers each with one response.
// A load into an empty run goes straight to the write; otherwise it first
// probes the last tail and, unless it extends the run or the run holds one
// tail, a binary search makes one probe per cycle through the single read port
// of the tail RAM. A clear goes straight to the response. The first read after
// a load walks the predecessor chain (per element, readout RAM write with item
// RAM read, then predecessor follow) and then returns the first element; every
// later read returns the next element, or none once the subsequence is used up.
// A new request is taken while the previous response still waits in the output
// register; its own response then holds until that register frees.

`include "longest_increasing_subsequence_engine_assert.svh"

module longest_increasing_subsequence_engine (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire lise_pkg::req_t req_data,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output lise_pkg::rsp_t      rsp_data
);

    lise_pkg::tail_port_t  tail_port;
    lise_pkg::tail_entry_t tail_rdata;
    lise_pkg::item_port_t  item_port;
    lise_pkg::item_entry_t item_rdata;
    lise_pkg::order_port_t order_port;
    logic [lise_pkg::IdxBits-1:0] order_rdata;
    lise_pkg::stat_t       stat;

    lise_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_data    (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp_data    (rsp_data),
        .tail_port   (tail_port),
        .tail_rdata  (tail_rdata),
        .item_port   (item_port),
        .item_rdata  (item_rdata),
        .order_port  (order_port),
        .order_rdata (order_rdata),
        .stat        (stat)
    );

    lise_ram #(
        .WIDTH ($bits(lise_pkg::tail_entry_t)),
        .DEPTH (lise_pkg::MaxItems)
    ) u_tail_ram (
        .clk   (clk),
        .we    (tail_port.we),
        .waddr (tail_port.waddr),
        .wdata (tail_port.wdata),
        .raddr (tail_port.raddr),
        .rdata (tail_rdata)
    );

    lise_ram #(
        .WIDTH ($bits(lise_pkg::item_entry_t)),
        .DEPTH (lise_pkg::MaxItems)
    ) u_item_ram (
        .clk   (clk),
        .we    (item_port.we),
        .waddr (item_port.waddr),
        .wdata (item_port.wdata),
        .raddr (item_port.raddr),
        .rdata (item_rdata)
    );

    lise_ram #(
        .WIDTH (lise_pkg::IdxBits),
        .DEPTH (lise_pkg::MaxItems)
    ) u_order_ram (
        .clk   (clk),
        .we    (order_port.we),
        .waddr (order_port.waddr),
        .wdata (order_port.wdata),
        .raddr (order_port.raddr),
        .rdata (order_rdata)
    );

    `LISE_ASSERT_ALWAYS(a_run_within_count, clk, rst_n, stat.run_length <= stat.item_count)

    `LISE_ASSERT_NEXT(a_clear_empties, clk, rst_n, req_valid && req_ready && req_data.func == lise_pkg::FuncClear, stat.item_count == '0 && stat.run_length == '0)

    `LISE_ASSERT_SAME(a_count_steps, clk, rst_n, stat.item_count != $past(stat.item_count), stat.item_count == ($past(stat.item_count) + lise_pkg::LenBits'(1)) || stat.item_count == '0)

endmodule

`default_nettype wire
